// ----- hw/rtl/knd_pkg.sv -----
// ----------------------------------------------------------------------------
// knd_pkg
// Shared types and constants for the knock pattern detector.
// ----------------------------------------------------------------------------
package knd_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int WINDOW_W   = 16;
    localparam int COUNT_W    = 8;
    localparam int EVENT_ID_W = 16;
    localparam int TYPE_W     = 2;
    localparam int CONF_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 48;  // 12 + 32 = 44 -> 48
    localparam int M_TDATA_W = 32;  // 8 + 16 + 7 = 31 -> 32

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 1'd1;

    // Reset values of the configuration registers
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 12'sd500;
    localparam logic [WINDOW_W-1:0]        WINDOW_MS_RST = 16'd1500;

    // Pattern constants
    localparam logic [COUNT_W-1:0] KNOCK_MIN_COUNT  = 8'd2;
    localparam logic [COUNT_W-1:0] KNOCK_CNT_MAX    = 8'hFF;
    localparam logic [CONF_W-1:0]  KNOCK_CONFIDENCE = 7'd95;
    localparam logic [TYPE_W-1:0]  EV_KIND_KNOCK    = 2'd0;

    // One input item
    typedef struct packed {
        logic [TIME_W-1:0]          time_ms;
        logic signed [SAMPLE_W-1:0] sample;
    } knd_in_t;

    // One result item (tdata part)
    typedef struct packed {
        logic [CONF_W-1:0]     confidence;
        logic [EVENT_ID_W-1:0] event_id;
        logic [COUNT_W-1:0]    knocks;
    } knd_out_t;

endpackage

// ----- hw/rtl/knock_pattern_detector_core.sv -----
// ----------------------------------------------------------------------------
// knock_pattern_detector_core
// Groups piezo knocks into patterns and emits one event per pattern.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one piezo sample with its millisecond timestamp.
//   m_* channel carries one knock event when a window closes on a quiet
//   sample after two or more knocks; most samples give no event.
//   cfg_we/cfg_index/cfg_wdata write threshold (index 0) or window_ms
//   (index 1); write only while the block is idle.
// Path: the sample that closes the window goes into the input register,
//   then through detection logic into the result register.
// Throughput: one sample per cycle except while the result stream stalls;
//   the pattern state is a single register set updated in one pass of
//   compare/subtract logic.
// Reset: aresetn low clears the window state, event counter and both
//   pipeline valids, and loads the register defaults (500, 1500 ms).
// Stall: while m_tready is low and an event is held, the input register
//   keeps its sample and s_tready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module knock_pattern_detector_core
    import knd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample, [43:12] time_ms, rest 0
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] knocks, [23:8] event_id,
                                             // [30:24] confidence, [31] 0
    output logic [TYPE_W-1:0]     m_tuser,   // [1:0] event kind
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic signed [SAMPLE_W-1:0] threshold_reg;
    logic [WINDOW_W-1:0]        window_ms_reg;

    // Input register
    logic    in_vld_reg;
    knd_in_t in_reg;

    // Pattern state
    logic                  window_open_reg, window_open_next;
    logic [TIME_W-1:0]     window_start_reg, window_start_next;
    logic [TIME_W-1:0]     last_knock_reg, last_knock_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [EVENT_ID_W-1:0] event_cnt_reg, event_cnt_next;

    // Result register
    logic     out_vld_reg;
    knd_out_t out_reg, out_next;

    // Detection signals
    logic              proc_fire;
    logic              is_knock;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] window_ext;
    logic              gap_short;
    logic              window_done;
    logic              emit;

    // Handshake: processing moves an item out of the input register
    assign proc_fire = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || proc_fire;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            window_ms_reg <= WINDOW_MS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= $signed(cfg_wdata[SAMPLE_W-1:0]);
                REG_WINDOW_MS: window_ms_reg <= cfg_wdata[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= knd_in_t'(s_tdata[SAMPLE_W+TIME_W-1:0]);
        end
    end

    // Elapsed times, modulo 2^32
    assign window_ext  = {{(TIME_W-WINDOW_W){1'b0}}, window_ms_reg};
    assign is_knock    = in_reg.sample > threshold_reg;
    assign gap         = in_reg.time_ms - last_knock_reg;
    assign elapsed     = in_reg.time_ms - window_start_reg;
    assign gap_short   = gap < window_ext;
    assign window_done = window_open_reg && (elapsed > window_ext);
    assign emit        = !is_knock && window_done && (count_reg >= KNOCK_MIN_COUNT);

    // Next pattern state and result
    always_comb begin
        window_open_next  = window_open_reg;
        window_start_next = window_start_reg;
        last_knock_next   = last_knock_reg;
        count_next        = count_reg;
        event_cnt_next    = event_cnt_reg;
        out_next          = out_reg;
        if (is_knock) begin
            if (!window_open_reg) begin
                window_open_next  = 1'b1;
                window_start_next = in_reg.time_ms;
                count_next        = COUNT_W'(1);
            end else if (gap_short && (count_reg != KNOCK_CNT_MAX)) begin
                count_next = count_reg + COUNT_W'(1);
            end
            last_knock_next = in_reg.time_ms;
        end else if (window_done) begin
            window_open_next = 1'b0;
            count_next       = '0;
            if (emit) begin
                event_cnt_next      = event_cnt_reg + EVENT_ID_W'(1);
                out_next.knocks     = count_reg;
                out_next.event_id   = event_cnt_next;
                out_next.confidence = KNOCK_CONFIDENCE;
            end
        end
    end

    // Pattern state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_open_reg  <= 1'b0;
            window_start_reg <= '0;
            last_knock_reg   <= '0;
            count_reg        <= '0;
            event_cnt_reg    <= '0;
        end else if (proc_fire) begin
            window_open_reg  <= window_open_next;
            window_start_reg <= window_start_next;
            last_knock_reg   <= last_knock_next;
            count_reg        <= count_next;
            event_cnt_reg    <= event_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc_fire) begin
            out_vld_reg <= emit;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-$bits(knd_out_t)){1'b0}}, out_reg};
    assign m_tuser  = EV_KIND_KNOCK;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A held event always reports a real pattern
    a_count_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.knocks >= KNOCK_MIN_COUNT))
        else $error("knock event with count below two");

    // Count is nonzero exactly while a window is open
    a_count_open: assert property (@(posedge aclk) disable iff (!aresetn)
        window_open_reg == (count_reg != '0))
        else $error("window flag and knock count disagree");

    // Each emitted event advances the id by one and carries it
    a_event_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && emit) |=>
            (event_cnt_reg == $past(event_cnt_reg) + EVENT_ID_W'(1)) &&
            (out_reg.event_id == event_cnt_reg) && m_tvalid)
        else $error("event id not advanced with emitted event");

    // The id moves only when an event is produced
    a_id_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(proc_fire && emit) |=> $stable(event_cnt_reg))
        else $error("event id changed without an event");

endmodule

// ----- test/tb_knock_pattern_detector_core.sv -----
// ----------------------------------------------------------------------------
// tb_knock_pattern_detector_core
// Self-checking bench for the knock pattern detector core. A short table of
// hand-picked samples comes first, then random knock patterns, noise and
// timestamp wraps under several threshold/window settings. Every sample
// transfer runs a local model of the pattern logic, and every event transfer
// on the result stream is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_knock_pattern_detector_core;
    import knd_pkg::*;

    // Row kinds of the directed table
    typedef enum int {
        CHK_MODEL,  // expectation comes from the model
        CHK_NONE,   // no event may follow this sample
        CHK_EVENT   // typed-in event follows this sample
    } chk_kind_t;

    typedef struct {
        chk_kind_t   kind;
        int          smp;
        logic [31:0] tms;
        int          cnt;
        int          id;
    } dir_row_t;

    typedef struct {
        logic [COUNT_W-1:0]    knocks;
        logic [EVENT_ID_W-1:0] event_id;
        logic [TYPE_W-1:0]     ev_kind;
        logic [CONF_W-1:0]     confidence;
    } knock_event_t;

    localparam int HOLD_CYCLES = 300;
    localparam int N_DIR       = 22;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [TYPE_W-1:0]     m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Model state and its copy of the registers
    logic signed [SAMPLE_W-1:0] cf_threshold;
    logic [WINDOW_W-1:0]        cf_window;
    logic                       pw_open;
    logic [TIME_W-1:0]          pw_start;
    logic [TIME_W-1:0]          pw_last;
    logic [COUNT_W-1:0]         pw_count;
    logic [EVENT_ID_W-1:0]      pw_events;

    knock_event_t pending_events[$];
    int           mismatch_count = 0;
    int           items_sent     = 0;
    logic [31:0]  now_ms;

    // Idle control shared with the receiver process
    logic calm      = 1'b0;
    logic hold_flip = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   rx_idle_left = 0;

    dir_row_t dir_rows [N_DIR] = '{
        '{CHK_NONE,  -2048, 32'd0,          0, 0},  // quiet, window closed
        '{CHK_MODEL,  2047, 32'd100,        0, 0},  // opens window
        '{CHK_MODEL,   501, 32'd200,        0, 0},  // just above threshold
        '{CHK_NONE,    500, 32'd1600,       0, 0},  // at threshold, elapsed == window
        '{CHK_EVENT, -2048, 32'd1601,       2, 1},  // closes with two knocks
        '{CHK_MODEL,  2047, 32'd2000,       0, 0},
        '{CHK_NONE,      0, 32'd3501,       0, 0},  // closes with one knock
        '{CHK_MODEL,  1000, 32'hFFFF_FF00,  0, 0},  // opens just before wrap
        '{CHK_MODEL,  1000, 32'h0000_0100,  0, 0},  // gap across wrap
        '{CHK_MODEL,  1000, 32'd1756,       0, 0},  // gap == window, count held
        '{CHK_MODEL,  1000, 32'd3255,       0, 0},  // gap window-1, counts
        '{CHK_EVENT,   499, 32'd3300,       3, 2},  // elapsed across wrap
        '{CHK_MODEL,  2047, 32'd10000,      0, 0},
        '{CHK_MODEL,  2047, 32'd10000,      0, 0},  // zero gap
        '{CHK_MODEL,   600, 32'd10001,      0, 0},
        '{CHK_MODEL,    -1, 32'd10500,      0, 0},  // quiet inside window
        '{CHK_MODEL,  2047, 32'd11000,      0, 0},
        '{CHK_MODEL,     0, 32'd11501,      0, 0},
        '{CHK_MODEL,  2047, 32'hFFFF_FFFF,  0, 0},
        '{CHK_MODEL,  2047, 32'd0,          0, 0},
        '{CHK_MODEL, -2048, 32'd1499,       0, 0},  // elapsed == window
        '{CHK_MODEL, -2048, 32'd1500,       0, 0}
    };

    knock_pattern_detector_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Pattern model: one step per accepted sample
    task automatic predict_knock_event(input logic signed [SAMPLE_W-1:0] smp,
                                       input logic [TIME_W-1:0] tms,
                                       output bit fired, output knock_event_t ev);
        logic [TIME_W-1:0] elapsed;
        fired = 1'b0;
        ev    = '{default: '0};
        if (smp > cf_threshold) begin
            elapsed = tms - pw_last;
            if (!pw_open) begin
                pw_open  = 1'b1;
                pw_start = tms;
                pw_count = 8'd1;
            end else if (elapsed < {16'd0, cf_window}) begin
                if (pw_count != KNOCK_CNT_MAX)
                    pw_count = pw_count + 8'd1;
            end
            pw_last = tms;
        end else begin
            elapsed = tms - pw_start;
            if (pw_open && elapsed > {16'd0, cf_window}) begin
                pw_open = 1'b0;
                if (pw_count >= KNOCK_MIN_COUNT) begin
                    pw_events     = pw_events + 16'd1;
                    fired         = 1'b1;
                    ev.knocks     = pw_count;
                    ev.event_id   = pw_events;
                    ev.ev_kind    = EV_KIND_KNOCK;
                    ev.confidence = KNOCK_CONFIDENCE;
                end
                pw_count = '0;
            end
        end
    endtask

    // One sample transfer, with an optional idle burst in front of it
    task automatic send_sample(input int smp, input logic [31:0] tms, input chk_kind_t kind,
                               input int cnt, input int id);
        int           idle;
        bit           fired;
        knock_event_t ev;
        if (!calm && $urandom_range(0, 4) == 0) begin
            idle = $urandom_range(1, 7);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            repeat (idle - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, tms, smp[SAMPLE_W-1:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        predict_knock_event(smp[SAMPLE_W-1:0], tms, fired, ev);
        if (kind == CHK_EVENT) begin
            ev.knocks     = cnt[COUNT_W-1:0];
            ev.event_id   = id[EVENT_ID_W-1:0];
            ev.ev_kind    = EV_KIND_KNOCK;
            ev.confidence = KNOCK_CONFIDENCE;
            pending_events.push_back(ev);
        end else if (kind == CHK_MODEL && fired) begin
            pending_events.push_back(ev);
        end
    endtask

    // Stop sending, wait for all events and let the pipeline empty
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_THRESHOLD)
            cf_threshold = data[SAMPLE_W-1:0];
        else if (idx == REG_WINDOW_MS)
            cf_window = data;
    endtask

    function automatic int knock_level();
        int t;
        t = cf_threshold;
        if (t >= 2047)
            return 2047;   // nothing can knock; sends a quiet sample
        return t + 1 + int'($urandom_range(0, 2046 - t));
    endfunction

    function automatic int quiet_level();
        int t;
        t = cf_threshold;
        return -2048 + int'($urandom_range(0, t + 2048));
    endfunction

    // Knock pattern with random content, then a closing quiet sample
    task automatic run_pattern();
        int          k;
        int          sel;
        int          win;
        int          i;
        logic [31:0] gap;
        logic [31:0] el;
        win = cf_window;
        k = ($urandom_range(0, 59) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 6);
        now_ms += $urandom_range(1, 3 * win + 3);
        send_sample(knock_level(), now_ms, CHK_MODEL, 0, 0);
        for (i = 1; i < k; i++) begin
            sel = $urandom_range(0, 7);
            if (sel == 0)
                gap = win + $urandom_range(0, 3);          // gap too long
            else if (sel == 1)
                gap = (win == 0) ? 0 : win - 1;            // longest gap that counts
            else
                gap = (win == 0) ? $urandom_range(0, 2) : $urandom_range(0, win - 1);
            if (k < 10 && $urandom_range(0, 3) == 0)
                send_sample(quiet_level(), now_ms + gap / 2, CHK_MODEL, 0, 0);
            now_ms += gap;
            send_sample(knock_level(), now_ms, CHK_MODEL, 0, 0);
        end
        // Close the window: sometimes probe the exact edge first
        el = now_ms - pw_start;
        if (!pw_open || el > win) begin
            now_ms += $urandom_range(0, 3);
        end else begin
            if ($urandom_range(0, 3) == 0)
                send_sample(quiet_level(), pw_start + win, CHK_MODEL, 0, 0);
            now_ms = pw_start + win + 1 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 50));
        end
        send_sample(quiet_level(), now_ms, CHK_MODEL, 0, 0);
    endtask

    // Random traffic until the phase has sent its share of samples
    task automatic run_traffic(input int n_items);
        int stop_at;
        int r;
        int n;
        int win;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            win = cf_window;
            r   = $urandom_range(0, 9);
            if (r < 7) begin
                run_pattern();
            end else if (r < 9) begin
                // Noise: any sample, time steps or jumps
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        now_ms = $urandom;
                    else
                        now_ms += $urandom_range(0, 2 * win + 2);
                    send_sample($urandom_range(0, 4095), now_ms, CHK_MODEL, 0, 0);
                end
            end else begin
                // Next pattern runs across the timestamp wrap
                now_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * win + 2);
            end
        end
    endtask

    task automatic run_phase(input logic [SAMPLE_W-1:0] thr, input logic [WINDOW_W-1:0] win,
                             input int n_items, input bit quiet_run, input bit long_hold);
        drain();
        write_reg(REG_THRESHOLD, {4'($urandom_range(0, 15)), thr});  // upper bits unused
        write_reg(REG_WINDOW_MS, win);
        calm <= quiet_run;
        if (long_hold)
            hold_flip <= ~hold_flip;
        run_traffic(n_items);
    endtask

    // Receiver: random idle bursts, one long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_flip) begin
            hold_seen <= hold_flip;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (rx_idle_left > 0) begin
            rx_idle_left <= rx_idle_left - 1;
            m_tready     <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_idle_left <= $urandom_range(0, 6);
            m_tready     <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Event checker: each result transfer against the oldest prediction
    always @(posedge aclk) begin
        knock_event_t exp_ev;
        knd_out_t     got;
        if (aresetn && m_tvalid && m_tready) begin
            got = knd_out_t'(m_tdata[$bits(knd_out_t)-1:0]);
            if (pending_events.size() == 0) begin
                $error("unexpected event: knocks %0d event_id %0d",
                       got.knocks, got.event_id);
                mismatch_count++;
            end else begin
                exp_ev = pending_events.pop_front();
                if (got.knocks !== exp_ev.knocks) begin
                    $error("knocks: expected %0d, got %0d",
                           exp_ev.knocks, got.knocks);
                    mismatch_count++;
                end
                if (got.event_id !== exp_ev.event_id) begin
                    $error("event_id: expected %0d, got %0d", exp_ev.event_id, got.event_id);
                    mismatch_count++;
                end
                if (m_tuser !== exp_ev.ev_kind) begin
                    $error("ev_kind: expected %0d, got %0d", exp_ev.ev_kind, m_tuser);
                    mismatch_count++;
                end
                if (got.confidence !== exp_ev.confidence) begin
                    $error("confidence: expected %0d, got %0d",
                           exp_ev.confidence, got.confidence);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        cf_threshold = THRESHOLD_RST;
        cf_window    = WINDOW_MS_RST;
        pw_open      = 1'b0;
        pw_start     = '0;
        pw_last      = '0;
        pw_count     = '0;
        pw_events    = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows under the reset settings
        for (int i = 0; i < N_DIR; i++)
            send_sample(dir_rows[i].smp, dir_rows[i].tms, dir_rows[i].kind,
                        dir_rows[i].cnt, dir_rows[i].id);
        now_ms = 32'd1500;
        run_traffic(250);

        run_phase(12'h800, 16'd1, 200, 1'b0, 1'b0);        // lowest threshold, shortest nonzero window
        run_phase(12'h7FF, 16'hFFFF, 60, 1'b0, 1'b0);      // nothing can knock
        run_phase(12'h7FE, 16'hFFFF, 200, 1'b0, 1'b0);     // only full-scale knocks
        run_phase(12'h000, 16'd0, 200, 1'b0, 1'b0);        // window of zero
        run_phase(12'($urandom_range(0, 4095)), 16'($urandom_range(1, 65535)), 300,
                  1'b0, 1'b0);
        run_phase(12'hFFF, 16'd20, 250, 1'b0, 1'b1);       // long receiver hold-off
        run_phase(12'($urandom_range(0, 4095)), 16'($urandom_range(1, 3000)), 250,
                  1'b1, 1'b0);

        // Wind down: all events in, then let the pipeline settle
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/knd_pkg.sv
hw/rtl/knock_pattern_detector_core.sv
test/tb_knock_pattern_detector_core.sv
